/* hdl/isd_pkg.sv */
// Shared types and constants for the indentation style detector.
`default_nettype none

package isd_pkg;

  localparam int MAX_TAB_WIDTH = 8;
  localparam int LINES         = 20;
  localparam int QUEUE_DEPTH   = 4;
  localparam int RUN_W         = 16;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 1;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STYLE = 1'd1;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_NEWLINE,
    TK_SPACE,
    TK_TAB,
    TK_TEXT
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      last;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCORE,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic score;
    logic finish;
  } back_ctl_t;

endpackage

`default_nettype wire

/* hdl/indentation_style_detector.sv */
// Top level of the indentation style detector.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_stall    | ch, no_char, last
//   out      | out_valid / out_stall  | indent_width, indent_style, width_detected,
//            |                        | style_detected
//   cfg      | cfg_we                 | cfg_index, cfg_data
//
// One byte beat per cycle, while in_stall is low, through the token queue into
// the line tracker. A beat with last starts candidate scoring (one width per
// cycle), then loads the result register when it is free; no token is taken then.
// Reset clears all text state; default_width resets to 4, default_style to 0.
// in_stall is high while the queue is full; out_stall holds the result register.
`default_nettype none

module indentation_style_detector #(
  parameter int MAX_TAB_WIDTH = isd_pkg::MAX_TAB_WIDTH,
  parameter int LINES         = isd_pkg::LINES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    ch,
  input  wire logic                          no_char,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [3:0]                         indent_width,
  output logic                               indent_style,
  output logic                               width_detected,
  output logic                               style_detected,
  input  wire logic                          cfg_we,
  input  wire logic [isd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [isd_pkg::CFG_W-1:0]     cfg_data
);

  logic [isd_pkg::CFG_W-1:0] default_width;
  logic                      default_style;

  isd_pkg::queue_stat_t qstat;
  isd_pkg::token_t      push_tok;
  isd_pkg::token_t      head;
  logic                 push;
  logic                 pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_width <= isd_pkg::CFG_W'(4);
      default_style <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        isd_pkg::CFG_DEFAULT_WIDTH: default_width <= cfg_data;
        isd_pkg::CFG_DEFAULT_STYLE: default_style <= cfg_data[0];
        default: ;
      endcase
    end
  end

  isd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .no_char  (no_char),
    .last     (last),
    .qstat    (qstat),
    .push     (push),
    .token    (push_tok)
  );

  isd_queue #(
    .DEPTH (isd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  isd_back #(
    .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
    .LINES         (LINES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .tok            (head),
    .qstat          (qstat),
    .pop            (pop),
    .default_width  (default_width),
    .default_style  (default_style),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .indent_width   (indent_width),
    .indent_style   (indent_style),
    .width_detected (width_detected),
    .style_detected (style_detected)
  );

endmodule

`default_nettype wire

/* hdl/isd_front.sv */
// Front end: takes input beats and classes each byte into a token.
`default_nettype none

module isd_front (
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         ch,
  input  wire logic               no_char,
  input  wire logic               last,
  input  wire isd_pkg::queue_stat_t qstat,
  output logic                    push,
  output isd_pkg::token_t         token
);

  isd_pkg::tok_kind_t kind;

  always_comb begin
    if (no_char) begin
      kind = isd_pkg::TK_NONE;
    end else begin
      case (ch)
        isd_pkg::CH_NEWLINE: kind = isd_pkg::TK_NEWLINE;
        isd_pkg::CH_SPACE:   kind = isd_pkg::TK_SPACE;
        isd_pkg::CH_TAB:     kind = isd_pkg::TK_TAB;
        default:             kind = isd_pkg::TK_TEXT;
      endcase
    end
  end

  assign in_stall   = qstat.full;
  assign push       = in_valid && !qstat.full;
  assign token.kind = kind;
  assign token.last = last;

endmodule

`default_nettype wire

/* hdl/isd_queue.sv */
// Small token queue between front and back.
`default_nettype none

module isd_queue #(
  parameter int DEPTH = isd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire isd_pkg::token_t push_tok,
  input  wire logic            pop,
  output isd_pkg::token_t      head,
  output isd_pkg::queue_stat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  isd_pkg::token_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign qstat.full  = (count == (AW+1)'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/isd_back.sv */
// Back end: line tracking, difference histogram, width scoring, result register.
`default_nettype none

module isd_back #(
  parameter int MAX_TAB_WIDTH = isd_pkg::MAX_TAB_WIDTH,
  parameter int LINES         = isd_pkg::LINES
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire isd_pkg::token_t           tok,
  input  wire isd_pkg::queue_stat_t      qstat,
  output logic                           pop,
  input  wire logic [isd_pkg::CFG_W-1:0] default_width,
  input  wire logic                      default_style,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [3:0]                     indent_width,
  output logic                           indent_style,
  output logic                           width_detected,
  output logic                           style_detected
);

  localparam int HW = $clog2(MAX_TAB_WIDTH + 1);
  localparam int CW = $clog2(LINES + 1);
  localparam int RW = isd_pkg::RUN_W;

  isd_pkg::back_state_t state;
  isd_pkg::back_state_t state_next;
  isd_pkg::back_ctl_t   ctl;

  logic [CW-1:0] line_index;
  logic          in_leading_ws;
  logic [RW-1:0] space_run;
  logic          saw_tab;
  logic [CW-1:0] space_line_count;
  logic [CW-1:0] tab_line_count;
  logic [CW-1:0] mixed_line_count;
  logic [RW-1:0] prev_indent;
  logic          have_prev;
  logic [CW-1:0] diff_hist [1:MAX_TAB_WIDTH];
  logic [CW-1:0] diff_total;

  logic [RW-1:0] diff;
  logic          diff_ok;
  logic [HW-1:0] diff_idx;

  logic [HW-1:0] cand;
  logic [HW-1:0] best_w;
  logic [CW-1:0] best_s;
  logic [CW-1:0] best_e;
  logic          amb;
  logic [CW-1:0] score;
  logic [CW-1:0] exact;

  logic [MAX_TAB_WIDTH:1] mult_row [0:MAX_TAB_WIDTH];

  logic [7:0]    wsel;
  logic          sdet;
  logic          wdet;
  logic          style_sel;
  logic [CW+1:0] thr_lhs;
  logic [CW+1:0] thr_rhs;

  // multiples of each candidate width, fixed at elaboration
  for (genvar c = 0; c <= MAX_TAB_WIDTH; c++) begin : g_row
    for (genvar m = 1; m <= MAX_TAB_WIDTH; m++) begin : g_col
      localparam int STEP = (c >= 2) ? c : 1;
      localparam bit HIT  = (c >= 2) && ((m % STEP) == 0);
      assign mult_row[c][m] = HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isd_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      isd_pkg::ST_RUN: begin
        if (ctl.pop && tok.last) begin
          state_next = isd_pkg::ST_SCORE;
        end
      end
      isd_pkg::ST_SCORE: begin
        if (cand == HW'(MAX_TAB_WIDTH)) begin
          state_next = isd_pkg::ST_DONE;
        end
      end
      isd_pkg::ST_DONE: begin
        if (ctl.finish) begin
          state_next = isd_pkg::ST_RUN;
        end
      end
      default: state_next = isd_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    ctl.pop    = 1'b0;
    ctl.score  = 1'b0;
    ctl.finish = 1'b0;
    case (state)
      isd_pkg::ST_RUN:   ctl.pop    = !qstat.empty;
      isd_pkg::ST_SCORE: ctl.score  = 1'b1;
      isd_pkg::ST_DONE:  ctl.finish = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign pop = ctl.pop;

  assign diff     = (space_run >= prev_indent) ? space_run - prev_indent
                                               : prev_indent - space_run;
  assign diff_ok  = (diff != '0) && (diff <= RW'(MAX_TAB_WIDTH));
  assign diff_idx = diff[HW-1:0];

  // line tracking and histogram
  always_ff @(posedge clk) begin
    if (rst || ctl.finish) begin
      line_index       <= '0;
      in_leading_ws    <= 1'b1;
      space_run        <= '0;
      saw_tab          <= 1'b0;
      space_line_count <= '0;
      tab_line_count   <= '0;
      mixed_line_count <= '0;
      prev_indent      <= '0;
      have_prev        <= 1'b0;
      diff_total       <= '0;
      for (int i = 1; i <= MAX_TAB_WIDTH; i++) begin
        diff_hist[i] <= '0;
      end
    end else if (ctl.pop && line_index < CW'(LINES)) begin
      case (tok.kind)
        isd_pkg::TK_NEWLINE: begin
          line_index    <= line_index + 1'b1;
          in_leading_ws <= 1'b1;
          space_run     <= '0;
          saw_tab       <= 1'b0;
        end
        isd_pkg::TK_SPACE: begin
          if (in_leading_ws && space_run != {RW{1'b1}}) begin
            space_run <= space_run + 1'b1;
          end
        end
        isd_pkg::TK_TAB: begin
          if (in_leading_ws) begin
            saw_tab <= 1'b1;
          end
        end
        isd_pkg::TK_TEXT: begin
          if (in_leading_ws) begin
            in_leading_ws <= 1'b0;
            if (space_run != '0 && !saw_tab) begin
              space_line_count <= space_line_count + 1'b1;
            end else if (saw_tab && space_run == '0) begin
              tab_line_count <= tab_line_count + 1'b1;
            end else if (saw_tab) begin
              mixed_line_count <= mixed_line_count + 1'b1;
            end
            if (!saw_tab) begin
              if (have_prev && diff_ok) begin
                diff_hist[diff_idx] <= diff_hist[diff_idx] + 1'b1;
                diff_total          <= diff_total + 1'b1;
              end
              prev_indent <= space_run;
              have_prev   <= 1'b1;
            end else begin
              have_prev <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // one candidate width per cycle
  always_comb begin
    score = '0;
    for (int m = 1; m <= MAX_TAB_WIDTH; m++) begin
      if (mult_row[cand][m]) begin
        score = score + diff_hist[m];
      end
    end
  end

  assign exact = diff_hist[cand];

  always_ff @(posedge clk) begin
    if (ctl.pop && tok.last) begin
      cand   <= HW'(2);
      best_w <= '0;
      best_s <= '0;
      best_e <= '0;
      amb    <= 1'b0;
    end else if (ctl.score) begin
      cand <= cand + 1'b1;
      if (score > best_s || (score == best_s && exact > best_e)) begin
        best_w <= cand;
        best_s <= score;
        best_e <= exact;
        amb    <= 1'b0;
      end else if (score != '0 && score == best_s && exact == best_e) begin
        amb <= 1'b1;
      end
    end
  end

  // final decision
  assign thr_lhs = {2'b00, best_s} + {1'b0, best_s, 1'b0};
  assign thr_rhs = {1'b0, diff_total, 1'b0};

  always_comb begin
    if (default_width > 8'(MAX_TAB_WIDTH)) begin
      wsel = 8'(MAX_TAB_WIDTH);
    end else if (default_width == '0) begin
      wsel = 8'd1;
    end else begin
      wsel = default_width;
    end
    style_sel = default_style;
    sdet      = 1'b0;
    wdet      = 1'b0;
    if (space_line_count != '0 && tab_line_count == '0 && mixed_line_count == '0) begin
      style_sel = 1'b0;
      sdet      = 1'b1;
    end else if (tab_line_count != '0 && space_line_count == '0
                 && mixed_line_count == '0) begin
      style_sel = 1'b1;
      sdet      = 1'b1;
    end
    if (sdet && !style_sel && diff_total != '0) begin
      if (diff_hist[1] == diff_total) begin
        wsel = 8'd1;
        wdet = 1'b1;
      end else if (best_w != '0 && !amb && thr_lhs >= thr_rhs) begin
        wsel = 8'(best_w);
        wdet = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      indent_width   <= wsel[3:0];
      indent_style   <= style_sel;
      width_detected <= wdet;
      style_detected <= sdet;
    end
  end

endmodule

`default_nettype wire

/* hdl/isd_checker.sv */
// Port-level checks for the indentation style detector, bound to the top level.
`default_nettype none

module isd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] indent_width,
  input wire logic       indent_style,
  input wire logic       width_detected,
  input wire logic       style_detected
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      $stable({indent_width, indent_style, width_detected, style_detected}))
    else $error("result beat changed while stalled");

  a_width_needs_spaces: assert property (@(posedge clk) disable iff (rst)
    out_valid && width_detected |-> style_detected && !indent_style)
    else $error("width detected without detected space style");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind indentation_style_detector isd_checker u_isd_checker (.*);

`default_nettype wire
